// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the sorted list table
// Capacity, derived widths, request and status codes, and the command bundle
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] data;
    } slt_cmd_t;

endpackage

// ===== rtl/slt_cell.sv =====
// ----------------------------------------------------------------------------
// slt_cell: one storage cell of the sorted list table
// Holds one value and its valid bit, compares it with the broadcast request
// value, and shifts toward its right or left neighbor on insert or delete.
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slt_pkg::slt_cmd_t                cmd,
    input  logic                             left_lt,
    input  logic                             left_valid,
    input  logic signed [slt_pkg::DATA_W-1:0] left_data,
    input  logic                             right_valid,
    input  logic signed [slt_pkg::DATA_W-1:0] right_data,
    output logic signed [slt_pkg::DATA_W-1:0] data,
    output logic                             valid,
    output logic                             lt,
    output logic                             eq
);

    logic signed [slt_pkg::DATA_W-1:0] data_reg;
    logic signed [slt_pkg::DATA_W-1:0] data_next;
    logic                              valid_reg;
    logic                              valid_next;

    assign lt    = valid_reg && (data_reg < cmd.data);
    assign eq    = valid_reg && (data_reg == cmd.data);
    assign data  = data_reg;
    assign valid = valid_reg;

    // Cells holding smaller values never move. On insert the first cell that
    // is not smaller takes the new word and the rest take their left neighbor.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.ins && !lt)
        begin
            if (left_lt)
            begin
                data_next  = cmd.data;
                valid_next = 1'b1;
            end
            else
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
        end
        else if (cmd.del && !lt)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: ascending table of signed values with insert, delete
// and search, built as a chain of compare-and-shift cells.
//
//   channel | handshake           | words
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_ready | req_type, value
//   out     | out_valid/out_ready | status, position, entry_count
//
// One request is taken per cycle while in_ready is high; its result appears
// in the output register on the next cycle. Every cell compares and shifts in
// parallel, so the rate is set by the output register only: in_ready is low
// only while a result waits and out_ready is low. Reset clears the valid bits
// of all cells and the count; the table is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sorted_list_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [3:0]         position,
    output logic [4:0]         entry_count
);

    localparam int CAP = slt_pkg::CAPACITY;
    localparam int CW  = slt_pkg::CNT_W;

    slt_pkg::slt_cmd_t                  cmd;
    logic signed [slt_pkg::DATA_W-1:0]  cell_data [CAP];
    logic [CAP-1:0]                     cell_valid;
    logic [CAP-1:0]                     cell_lt;
    logic [CAP-1:0]                     cell_eq;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] lt_count;
    logic          accept;
    logic          full;
    logic          found;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [3:0]    position_reg;
    logic [3:0]    position_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(CAP));
    assign found    = |cell_eq;

    assign cmd.data = value;
    assign cmd.ins  = accept && (req_type == slt_pkg::REQ_INSERT) && !full;
    assign cmd.del  = accept && (req_type == slt_pkg::REQ_DELETE) && found;

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                slt_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .left_lt     (1'b1),
                    .left_valid  (1'b0),
                    .left_data   (value),
                    .right_valid (cell_valid[g+1]),
                    .right_data  (cell_data[g+1]),
                    .data        (cell_data[g]),
                    .valid       (cell_valid[g]),
                    .lt          (cell_lt[g]),
                    .eq          (cell_eq[g])
                );
            end
            else if (g == CAP - 1)
            begin : g_last
                slt_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .left_lt     (cell_lt[g-1]),
                    .left_valid  (cell_valid[g-1]),
                    .left_data   (cell_data[g-1]),
                    .right_valid (1'b0),
                    .right_data  (value),
                    .data        (cell_data[g]),
                    .valid       (cell_valid[g]),
                    .lt          (cell_lt[g]),
                    .eq          (cell_eq[g])
                );
            end
            else
            begin : g_mid
                slt_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .left_lt     (cell_lt[g-1]),
                    .left_valid  (cell_valid[g-1]),
                    .left_data   (cell_data[g-1]),
                    .right_valid (cell_valid[g+1]),
                    .right_data  (cell_data[g+1]),
                    .data        (cell_data[g]),
                    .valid       (cell_valid[g]),
                    .lt          (cell_lt[g]),
                    .eq          (cell_eq[g])
                );
            end
        end
    endgenerate

    // The smaller-than flags form a prefix of the valid cells, so their count
    // is both the insert slot and the index of the first equal entry.
    always_comb
    begin
        lt_count = '0;
        for (int i = 0; i < CAP; i++)
        begin
            lt_count = lt_count + CW'(cell_lt[i]);
        end
    end

    always_comb
    begin
        status_next   = slt_pkg::ST_MISSING;
        position_next = '0;
        count_next    = count_reg;
        unique case (req_type)
            slt_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = slt_pkg::ST_FULL;
                end
                else
                begin
                    status_next   = slt_pkg::ST_OK;
                    position_next = 4'(lt_count);
                    count_next    = count_reg + CW'(1);
                end
            end
            slt_pkg::REQ_DELETE:
            begin
                if (found)
                begin
                    status_next   = slt_pkg::ST_OK;
                    position_next = 4'(lt_count);
                    count_next    = count_reg - CW'(1);
                end
            end
            slt_pkg::REQ_SEARCH:
            begin
                if (found)
                begin
                    status_next   = slt_pkg::ST_OK;
                    position_next = 4'(lt_count);
                end
            end
            default:
            begin
                status_next = slt_pkg::ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    logic [CW-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            position_reg  <= position_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = 5'(count_out_reg);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("entry count above capacity");

    // The valid cells always match the count.
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("valid cells disagree with count");

    // Valid cells form a prefix of the chain.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + CAP'(1)) & cell_valid) == '0)
        else $error("hole in valid cells");

    // An insert into a table with room grows it by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow table");

    // Every accepted word yields a pending result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("result missing after accept");

endmodule
